FILE: sv/ipv4e_pkg.sv
`timescale 1ns / 1ps

package ipv4e_pkg;

	typedef enum logic [2:0] {
		CMD_REWIND      = 3'd0,
		CMD_NEXT        = 3'd1,
		CMD_RETURN_LAST = 3'd2,
		CMD_SKIP        = 3'd3,
		CMD_LOAD        = 3'd4
	} command_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_ERROR = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CFG_MODE          = 3'd0,
		CFG_START_ADDRESS = 3'd1,
		CFG_END_ADDRESS   = 3'd2,
		CFG_LAST_FIRST    = 3'd3,
		CFG_LAST_SECOND   = 3'd4,
		CFG_LAST_THIRD    = 3'd5,
		CFG_LAST_FOURTH   = 3'd6
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MUL,
		ST_EXEC
	} state_t;

	localparam int unsigned NUM_OCTETS = 4;
	localparam logic [1:0] LAST_OCTET = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic       latch;
		logic       mul_init;
		logic       mul_step;
		logic [1:0] step;
		logic       exec;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_mul;
	} dp_status_t;

endpackage

FILE: sv/ipv4e_list_mem.sv
`timescale 1ns / 1ps

module ipv4e_list_mem #(
	parameter int LIST_DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [1:0]                            wbank,
	input  logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] waddr,
	input  logic [7:0]                            wdata,
	input  logic [3:0][((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] raddr,
	output logic [3:0][7:0]                       rdata
);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [7:0] mem [LIST_DEPTH];
		logic [7:0] rd_q;

		always_ff @(posedge clk) begin
			if (we && (wbank == 2'(b))) begin
				mem[waddr] <= wdata;
			end
			rd_q <= mem[raddr[b]];
		end

		assign rdata[b] = rd_q;
	end

endmodule

FILE: sv/ipv4e_datapath.sv
`timescale 1ns / 1ps

module ipv4e_datapath #(
	parameter int LIST_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ipv4e_pkg::ctrl_cmd_t   ctrl,
	output ipv4e_pkg::dp_status_t  dp_stat,
	input  logic [2:0]             command,
	input  logic [1:0]             octet_select,
	input  logic [7:0]             entry_index,
	input  logic [7:0]             entry_value,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	output logic [1:0]             status,
	output logic [31:0]            address,
	output logic [24:0]            skip_count,
	output logic [32:0]            remaining
);

	localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam logic [7:0] LastMax = 8'(LIST_DEPTH - 1);
	localparam logic [8:0] DepthLim = 9'(LIST_DEPTH);
	localparam logic [32:0] LeftMax = '1;

	// latched command beat
	logic [2:0] cmd_q;
	logic [1:0] sel_q;
	logic [7:0] idx_q;
	logic [7:0] val_q;

	// configuration
	logic            mode_q;
	logic [31:0]     start_addr_q;
	logic [31:0]     end_addr_q;
	logic [3:0][7:0] last_q;

	// enumeration state
	logic [3:0][8:0] pos_q;
	logic [31:0]     cur_q;
	logic [32:0]     left_q;

	logic [32:0] acc_q;

	logic [1:0]  stat_q;
	logic [31:0] addr_q;
	logic [24:0] skip_q;

	logic [3:0][7:0]    eff;
	logic [3:0][7:0]    rd_data;
	logic [3:0][7:0]    rv;
	logic [3:0][IW-1:0] raddr;

	logic       use_factor;
	logic [8:0] factor;
	logic [41:0] prod;

	logic [1:0]      inc_lim;
	logic [3:0][8:0] pos_inc;
	logic            carry;
	logic [3:0][8:0] pos_dec;
	logic            borrow;
	logic            any_pos;

	logic [33:0] left_plus;
	logic [33:0] acc_ext;

	logic [3:0][8:0] new_pos;
	logic [31:0]     new_cur;
	logic [32:0]     new_left;
	logic [1:0]      res_stat;
	logic [31:0]     res_addr;
	logic [24:0]     res_skip;
	logic            mem_we;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			eff[k]   = (last_q[k] > LastMax) ? LastMax : last_q[k];
			raddr[k] = pos_q[k][IW-1:0];
			rv[k]    = (pos_q[k] < DepthLim) ? rd_data[k] : 8'd0;
		end
	end

	ipv4e_list_mem #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.wbank (sel_q),
		.waddr (idx_q[IW-1:0]),
		.wdata (val_q),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign dp_stat.need_mul = mode_q && ((cmd_q == ipv4e_pkg::CMD_REWIND) ||
		((cmd_q == ipv4e_pkg::CMD_SKIP) && (sel_q != ipv4e_pkg::LAST_OCTET)));

	// shared multiplier: host count of the selected lists, one factor a cycle
	assign use_factor = (cmd_q == ipv4e_pkg::CMD_REWIND) || (ctrl.step > sel_q);
	assign factor     = use_factor ? ({1'b0, eff[ctrl.step]} + 9'd1) : 9'd1;
	assign prod       = acc_q * factor;

	// odometer advance over octets up to inc_lim, lower octets cleared
	assign inc_lim = (cmd_q == ipv4e_pkg::CMD_SKIP) ? sel_q : ipv4e_pkg::LAST_OCTET;

	always_comb begin
		carry = 1'b1;
		for (int k = 3; k >= 0; k--) begin
			pos_inc[k] = pos_q[k];
			if (2'(k) > inc_lim) begin
				pos_inc[k] = '0;
			end else if (carry) begin
				if (pos_q[k] < {1'b0, eff[k]}) begin
					pos_inc[k] = pos_q[k] + 9'd1;
					carry = 1'b0;
				end else begin
					pos_inc[k] = '0;
				end
			end
		end
	end

	always_comb begin
		borrow = 1'b1;
		for (int k = 3; k >= 0; k--) begin
			pos_dec[k] = pos_q[k];
			if (borrow) begin
				if (pos_q[k] != 9'd0) begin
					pos_dec[k] = pos_q[k] - 9'd1;
					borrow = 1'b0;
				end else begin
					pos_dec[k] = {1'b0, eff[k]};
				end
			end
		end
	end

	assign any_pos = (pos_q[0] != 9'd0) || (pos_q[1] != 9'd0) ||
		(pos_q[2] != 9'd0) || (pos_q[3] != 9'd0);
	assign left_plus = {1'b0, left_q} + 34'd1;
	assign acc_ext   = {1'b0, acc_q};

	always_comb begin
		new_pos  = pos_q;
		new_cur  = cur_q;
		new_left = left_q;
		res_stat = ipv4e_pkg::STAT_OK;
		res_addr = '0;
		res_skip = '0;
		mem_we   = 1'b0;
		case (cmd_q)
			ipv4e_pkg::CMD_REWIND: begin
				if (!mode_q) begin
					new_cur = start_addr_q;
					if (start_addr_q <= end_addr_q) begin
						new_left = {1'b0, end_addr_q - start_addr_q} + 33'd1;
					end else begin
						new_left = '0;
						res_stat = ipv4e_pkg::STAT_ERROR;
					end
				end else begin
					new_pos  = '0;
					new_left = acc_q;
				end
			end
			ipv4e_pkg::CMD_NEXT: begin
				if (left_q == 33'd0) begin
					res_stat = ipv4e_pkg::STAT_EMPTY;
				end else if (!mode_q) begin
					if (cur_q <= end_addr_q) begin
						res_addr = cur_q;
						new_cur  = cur_q + 32'd1;
						new_left = left_q - 33'd1;
					end else begin
						new_left = '0;
						res_stat = ipv4e_pkg::STAT_ERROR;
					end
				end else begin
					res_addr = {rv[0], rv[1], rv[2], rv[3]};
					if (carry) begin
						// last address taken: park on the final position
						for (int k = 0; k < 4; k++) begin
							new_pos[k] = {1'b0, eff[k]};
						end
						new_pos[3] = {1'b0, eff[3]} + 9'd1;
					end else begin
						new_pos = pos_inc;
					end
					new_left = left_q - 33'd1;
				end
			end
			ipv4e_pkg::CMD_RETURN_LAST: begin
				if (left_q == LeftMax) begin
					res_stat = ipv4e_pkg::STAT_ERROR;
				end else if (!mode_q) begin
					if (cur_q > start_addr_q) begin
						new_cur  = cur_q - 32'd1;
						new_left = left_q + 33'd1;
					end else begin
						res_stat = ipv4e_pkg::STAT_ERROR;
					end
				end else if (!any_pos) begin
					res_stat = ipv4e_pkg::STAT_ERROR;
				end else begin
					new_pos  = pos_dec;
					new_left = left_q + 33'd1;
				end
			end
			ipv4e_pkg::CMD_SKIP: begin
				if (!mode_q || (sel_q == ipv4e_pkg::LAST_OCTET)) begin
					res_stat = ipv4e_pkg::STAT_ERROR;
				end else begin
					res_skip = acc_q[24:0];
					if (left_plus < acc_ext) begin
						res_stat = ipv4e_pkg::STAT_ERROR;
					end else begin
						new_pos  = pos_inc;
						new_left = 33'(left_plus - acc_ext);
					end
				end
			end
			ipv4e_pkg::CMD_LOAD: begin
				if ({1'b0, idx_q} < DepthLim) begin
					mem_we = ctrl.exec;
				end else begin
					res_stat = ipv4e_pkg::STAT_ERROR;
				end
			end
			default: begin
				res_stat = ipv4e_pkg::STAT_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			cmd_q <= command;
			sel_q <= octet_select;
			idx_q <= entry_index;
			val_q <= entry_value;
		end
		if (ctrl.mul_init) begin
			acc_q <= 33'd1;
		end else if (ctrl.mul_step) begin
			acc_q <= prod[32:0];
		end
		if (ctrl.exec) begin
			stat_q <= res_stat;
			addr_q <= res_addr;
			skip_q <= res_skip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			start_addr_q <= '0;
			end_addr_q   <= '0;
			last_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ipv4e_pkg::CFG_MODE:          mode_q       <= cfg_data[0];
				ipv4e_pkg::CFG_START_ADDRESS: start_addr_q <= cfg_data;
				ipv4e_pkg::CFG_END_ADDRESS:   end_addr_q   <= cfg_data;
				ipv4e_pkg::CFG_LAST_FIRST:    last_q[0]    <= cfg_data[7:0];
				ipv4e_pkg::CFG_LAST_SECOND:   last_q[1]    <= cfg_data[7:0];
				ipv4e_pkg::CFG_LAST_THIRD:    last_q[2]    <= cfg_data[7:0];
				ipv4e_pkg::CFG_LAST_FOURTH:   last_q[3]    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cur_q  <= '0;
			left_q <= '0;
		end else if (ctrl.exec) begin
			pos_q  <= new_pos;
			cur_q  <= new_cur;
			left_q <= new_left;
		end
	end

	assign status     = stat_q;
	assign address    = addr_q;
	assign skip_count = skip_q;
	assign remaining  = left_q;

endmodule

FILE: sv/ipv4e_ctrl.sv
`timescale 1ns / 1ps

module ipv4e_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	input  ipv4e_pkg::dp_status_t dp_stat,
	output ipv4e_pkg::ctrl_cmd_t  ctrl
);

	ipv4e_pkg::state_t state_q;
	ipv4e_pkg::state_t state_nxt;
	logic [1:0] step_q;
	logic       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipv4e_pkg::ST_IDLE;
			step_q  <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= ctrl.exec;
			if (ctrl.mul_init) begin
				step_q <= 2'd0;
			end else if (ctrl.mul_step) begin
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_nxt     = state_q;
		ctrl          = '0;
		ctrl.step     = step_q;
		case (state_q)
			ipv4e_pkg::ST_IDLE: begin
				if (start) begin
					ctrl.latch = 1'b1;
					state_nxt  = ipv4e_pkg::ST_FETCH;
				end
			end
			ipv4e_pkg::ST_FETCH: begin
				// list banks read at the current positions this cycle
				ctrl.mul_init = 1'b1;
				state_nxt = dp_stat.need_mul ? ipv4e_pkg::ST_MUL : ipv4e_pkg::ST_EXEC;
			end
			ipv4e_pkg::ST_MUL: begin
				ctrl.mul_step = 1'b1;
				if (step_q == ipv4e_pkg::LAST_OCTET) begin
					state_nxt = ipv4e_pkg::ST_EXEC;
				end
			end
			ipv4e_pkg::ST_EXEC: begin
				ctrl.exec = 1'b1;
				state_nxt = ipv4e_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = ipv4e_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ipv4e_pkg::ST_IDLE);
	assign done = done_q;

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ipv4e_pkg::ST_EXEC))
		else $error("result strobe without an execute cycle");

	a_accept_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ipv4e_pkg::ST_FETCH))
		else $error("accepted beat did not reach fetch");

	a_mul_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ipv4e_pkg::ST_MUL && step_q == ipv4e_pkg::LAST_OCTET)
		|=> (state_q == ipv4e_pkg::ST_EXEC))
		else $error("multiply sequence overran four factors");

	a_step_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ipv4e_pkg::ST_FETCH) |=> (step_q == 2'd0))
		else $error("factor counter not cleared");

endmodule

FILE: sv/ipv4_target_address_enumerator.sv
`timescale 1ns / 1ps
// Sequence: an accepted beat goes to fetch, then to execute, which registers the result
//   strobe; rewind and skip of octets 0 to 2 in list mode add a multiply state between
//   them, one factor a cycle through the multiplier. A new command is taken only when
//   idle; the next beat may be taken in the cycle that the previous result is shown.
// Reset: arst_n clears config, positions, current address and count, not results; list
//   banks unset until loaded. The receiver cannot stall: each result shows for one cycle.

module ipv4_target_address_enumerator #(
	parameter int LIST_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [1:0]  octet_select,
	input  logic [7:0]  entry_index,
	input  logic [7:0]  entry_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] address,
	output logic [24:0] skip_count,
	output logic [32:0] remaining
);

	ipv4e_pkg::ctrl_cmd_t  ctrl;
	ipv4e_pkg::dp_status_t dp_stat;

	assign cfg_ready = 1'b1;

	ipv4e_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.done    (done),
		.dp_stat (dp_stat),
		.ctrl    (ctrl)
	);

	ipv4e_datapath #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.dp_stat      (dp_stat),
		.command      (command),
		.octet_select (octet_select),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.status       (status),
		.address      (address),
		.skip_count   (skip_count),
		.remaining    (remaining)
	);

endmodule

FILE: dv/enumerator_checker.sv
`timescale 1ns / 1ps

module enumerator_checker #(
	parameter int LIST_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  command,
	input  logic [1:0]  octet_select,
	input  logic [7:0]  entry_index,
	input  logic [7:0]  entry_value,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [31:0] address,
	input  logic [24:0] skip_count,
	input  logic [32:0] remaining,
	output int unsigned mismatches,
	output int unsigned outstanding,
	output int unsigned results_checked
);

	localparam int          REPORT_LIMIT = 10;
	localparam logic [32:0] LEFT_MAX     = 33'h1_FFFF_FFFF;

	typedef struct packed {
		ipv4e_pkg::status_t st;
		logic [31:0]        addr;
		logic [24:0]        skipped;
		logic [32:0]        left;
	} outcome_t;

	logic [7:0]  octet_mem [ipv4e_pkg::NUM_OCTETS][LIST_DEPTH];
	logic [8:0]  digit [ipv4e_pkg::NUM_OCTETS];
	logic [31:0] cur_addr;
	logic [32:0] hosts_left;
	logic        mode_r;
	logic [31:0] start_r;
	logic [31:0] end_r;
	logic [7:0]  last_r [ipv4e_pkg::NUM_OCTETS];

	outcome_t    awaited_outcomes [$];
	int unsigned n_bad;
	int unsigned n_checked;

	function automatic logic [8:0] list_end(int k);
		logic [8:0] v;
		v = {1'b0, last_r[k]};
		if (v > 9'(LIST_DEPTH - 1))
			v = 9'(LIST_DEPTH - 1);
		return v;
	endfunction

	function automatic logic [7:0] list_value(int k);
		logic [7:0] v;
		v = 8'h00;
		if (digit[k] < 9'(LIST_DEPTH))
			v = octet_mem[k][digit[k]];
		return v;
	endfunction

	// hosts covered by one step of digit first-1, i.e. product of the lower lists
	function automatic logic [63:0] block_size(int first);
		logic [63:0] n;
		n = 64'd1;
		for (int k = first; k < ipv4e_pkg::NUM_OCTETS; k++)
			n = n * (64'(list_end(k)) + 64'd1);
		return n;
	endfunction

	// odometer increment from digit top upward; returns 1 when every digit wrapped
	function automatic logic step_up(int top);
		for (int k = top; k >= 0; k--) begin
			if (digit[k] < list_end(k)) begin
				digit[k] = digit[k] + 9'd1;
				return 1'b0;
			end
			digit[k] = '0;
		end
		return 1'b1;
	endfunction

	function automatic outcome_t advance_enumerator(logic [2:0] cmd, logic [1:0] sel,
			logic [7:0] idx, logic [7:0] val);
		outcome_t    o;
		logic [63:0] n;
		logic        any_set;
		o.st      = ipv4e_pkg::STAT_OK;
		o.addr    = '0;
		o.skipped = '0;
		any_set   = 1'b0;
		for (int k = 0; k < ipv4e_pkg::NUM_OCTETS; k++)
			any_set = any_set | (digit[k] != '0);
		case (cmd)
			ipv4e_pkg::CMD_REWIND: begin
				if (!mode_r) begin
					cur_addr = start_r;
					if (start_r <= end_r) begin
						hosts_left = {1'b0, end_r - start_r} + 33'd1;
					end else begin
						hosts_left = '0;
						o.st = ipv4e_pkg::STAT_ERROR;
					end
				end else begin
					for (int k = 0; k < ipv4e_pkg::NUM_OCTETS; k++)
						digit[k] = '0;
					hosts_left = 33'(block_size(0));
				end
			end
			ipv4e_pkg::CMD_NEXT: begin
				if (hosts_left == '0) begin
					o.st = ipv4e_pkg::STAT_EMPTY;
				end else if (!mode_r) begin
					if (cur_addr <= end_r) begin
						o.addr     = cur_addr;
						cur_addr   = cur_addr + 32'd1;
						hosts_left = hosts_left - 33'd1;
					end else begin
						hosts_left = '0;
						o.st = ipv4e_pkg::STAT_ERROR;
					end
				end else begin
					o.addr = {list_value(0), list_value(1), list_value(2), list_value(3)};
					if (step_up(ipv4e_pkg::LAST_OCTET)) begin
						// ran off the end: park on the last entries, final digit one past
						for (int k = 0; k < ipv4e_pkg::NUM_OCTETS; k++)
							digit[k] = list_end(k);
						digit[ipv4e_pkg::LAST_OCTET] =
							list_end(ipv4e_pkg::LAST_OCTET) + 9'd1;
					end
					hosts_left = hosts_left - 33'd1;
				end
			end
			ipv4e_pkg::CMD_RETURN_LAST: begin
				if (hosts_left == LEFT_MAX) begin
					o.st = ipv4e_pkg::STAT_ERROR;
				end else if (!mode_r) begin
					if (cur_addr > start_r) begin
						cur_addr   = cur_addr - 32'd1;
						hosts_left = hosts_left + 33'd1;
					end else begin
						o.st = ipv4e_pkg::STAT_ERROR;
					end
				end else if (!any_set) begin
					o.st = ipv4e_pkg::STAT_ERROR;
				end else begin
					for (int k = ipv4e_pkg::LAST_OCTET; k >= 0; k--) begin
						if (digit[k] != '0) begin
							digit[k] = digit[k] - 9'd1;
							break;
						end
						digit[k] = list_end(k);
					end
					hosts_left = hosts_left + 33'd1;
				end
			end
			ipv4e_pkg::CMD_SKIP: begin
				if (!mode_r || sel == ipv4e_pkg::LAST_OCTET) begin
					o.st = ipv4e_pkg::STAT_ERROR;
				end else begin
					n = block_size(int'(sel) + 1);
					o.skipped = n[24:0];
					if (64'(hosts_left) + 64'd1 < n) begin
						o.st = ipv4e_pkg::STAT_ERROR;
					end else begin
						void'(step_up(int'(sel)));
						for (int k = int'(sel) + 1; k < ipv4e_pkg::NUM_OCTETS; k++)
							digit[k] = '0;
						hosts_left = 33'(64'(hosts_left) + 64'd1 - n);
					end
				end
			end
			ipv4e_pkg::CMD_LOAD: begin
				if (int'(idx) < LIST_DEPTH)
					octet_mem[sel][idx] = val;
				else
					o.st = ipv4e_pkg::STAT_ERROR;
			end
			default: o.st = ipv4e_pkg::STAT_ERROR;
		endcase
		o.left = hosts_left;
		return o;
	endfunction

	function automatic void flag_field(string field, logic [63:0] want, logic [63:0] got);
		n_bad++;
		if (n_bad <= REPORT_LIMIT)
			$display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int k = 0; k < ipv4e_pkg::NUM_OCTETS; k++) begin
				digit[k]  = '0;
				last_r[k] = '0;
			end
			cur_addr   = '0;
			hosts_left = '0;
			mode_r     = 1'b0;
			start_r    = '0;
			end_r      = '0;
			awaited_outcomes.delete();
			n_bad      = 0;
			n_checked  = 0;
			mismatches      <= 0;
			outstanding     <= 0;
			results_checked <= 0;
		end else begin
			if (done !== 1'b0) begin
				if (awaited_outcomes.size() == 0) begin
					n_bad++;
					if (n_bad <= REPORT_LIMIT)
						$display("[%0t] result beat with nothing outstanding", $time);
				end else begin
					want = awaited_outcomes.pop_front();
					n_checked++;
					if (status !== want.st)
						flag_field("status", 64'(want.st), 64'(status));
					if (address !== want.addr)
						flag_field("address", 64'(want.addr), 64'(address));
					if (skip_count !== want.skipped)
						flag_field("skip_count", 64'(want.skipped), 64'(skip_count));
					if (remaining !== want.left)
						flag_field("remaining", 64'(want.left), 64'(remaining));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ipv4e_pkg::CFG_MODE:          mode_r    = cfg_data[0];
					ipv4e_pkg::CFG_START_ADDRESS: start_r   = cfg_data;
					ipv4e_pkg::CFG_END_ADDRESS:   end_r     = cfg_data;
					ipv4e_pkg::CFG_LAST_FIRST:    last_r[0] = cfg_data[7:0];
					ipv4e_pkg::CFG_LAST_SECOND:   last_r[1] = cfg_data[7:0];
					ipv4e_pkg::CFG_LAST_THIRD:    last_r[2] = cfg_data[7:0];
					ipv4e_pkg::CFG_LAST_FOURTH:   last_r[3] = cfg_data[7:0];
					default: ;
				endcase
			end
			if (start && !busy)
				awaited_outcomes.push_back(advance_enumerator(command, octet_select,
					entry_index, entry_value));
			mismatches      <= n_bad;
			outstanding     <= awaited_outcomes.size();
			results_checked <= n_checked;
		end
	end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int          TOTAL_BEATS  = 1950;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int          DRAIN_CYCLES = 12;
	localparam logic [2:0]  CMD_SPARE_LO = ipv4e_pkg::CMD_LOAD + 3'd1;
	localparam logic [2:0]  CMD_SPARE_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  command;
	logic [1:0]  octet_select;
	logic [7:0]  entry_index;
	logic [7:0]  entry_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        done;
	logic [1:0]  status;
	logic [31:0] address;
	logic [24:0] skip_count;
	logic [32:0] remaining;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned results_checked;

	int unsigned cycles     = 0;
	int unsigned beats_sent = 0;
	int unsigned phases_run = 1;
	int unsigned burst_left = 0;
	bit          loaded [ipv4e_pkg::NUM_OCTETS][256];
	logic        cur_mode;
	logic [7:0]  cur_last [ipv4e_pkg::NUM_OCTETS];

	ipv4_target_address_enumerator u_top (.*);

	enumerator_checker u_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
			$display("Regression FAIL");
			$finish;
		end
	end

	// one command beat; start is left high so a burst can follow back to back
	task automatic send_beat(input logic [2:0] cmd, input logic [1:0] sel,
			input logic [7:0] idx, input logic [7:0] val);
		@(negedge clk);
		start        <= 1'b1;
		command      <= cmd;
		octet_select <= sel;
		entry_index  <= idx;
		entry_value  <= val;
		do @(posedge clk); while (busy !== 1'b0);
		if (cmd == ipv4e_pkg::CMD_LOAD)
			loaded[sel][idx] = 1'b1;
		beats_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk) start <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic write_reg(input ipv4e_pkg::cfg_index_t idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk) start <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// new register setting; in list mode every entry the odometer can reach is loaded
	// first (fourth list one further, where it parks after the last address)
	task automatic configure(input logic m, input logic [31:0] first, input logic [31:0] final_addr,
			input logic [7:0] l0, input logic [7:0] l1, input logic [7:0] l2,
			input logic [7:0] l3);
		int top;
		cur_mode    = m;
		cur_last[0] = l0;
		cur_last[1] = l1;
		cur_last[2] = l2;
		cur_last[3] = l3;
		write_reg(ipv4e_pkg::CFG_MODE, {31'b0, m});
		write_reg(ipv4e_pkg::CFG_START_ADDRESS, first);
		write_reg(ipv4e_pkg::CFG_END_ADDRESS, final_addr);
		write_reg(ipv4e_pkg::CFG_LAST_FIRST, {24'b0, l0});
		write_reg(ipv4e_pkg::CFG_LAST_SECOND, {24'b0, l1});
		write_reg(ipv4e_pkg::CFG_LAST_THIRD, {24'b0, l2});
		write_reg(ipv4e_pkg::CFG_LAST_FOURTH, {24'b0, l3});
		phases_run++;
		if (m) begin
			for (int k = 0; k < ipv4e_pkg::NUM_OCTETS; k++) begin
				top = int'(cur_last[k]) + ((k == ipv4e_pkg::LAST_OCTET) ? 1 : 0);
				if (top > 255)
					top = 255;
				for (int i = 0; i <= top; i++)
					if (!loaded[k][i])
						send_beat(ipv4e_pkg::CMD_LOAD, 2'(k), 8'(i), 8'($urandom));
			end
			// stale digits from an earlier setting must not survive
			send_beat(ipv4e_pkg::CMD_REWIND, 2'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	function automatic logic [7:0] pick_last();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(1, 6));
		endcase
	endfunction

	initial begin
		logic [2:0]  cmd;
		logic [1:0]  sel;
		logic [31:0] first;
		logic [31:0] final_addr;
		logic [7:0]  l [ipv4e_pkg::NUM_OCTETS];
		int          r;
		int          n;
		arst_n       = 1'b0;
		start        = 1'b0;
		command      = ipv4e_pkg::CMD_REWIND;
		octet_select = '0;
		entry_index  = '0;
		entry_value  = '0;
		cfg_valid    = 1'b0;
		cfg_index    = ipv4e_pkg::CFG_MODE;
		cfg_data     = '0;
		cur_mode     = 1'b0;
		for (int k = 0; k < ipv4e_pkg::NUM_OCTETS; k++)
			cur_last[k] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// reset setting: one-address block at 0
		send_beat(ipv4e_pkg::CMD_NEXT, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_RETURN_LAST, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_REWIND, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_NEXT, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_RETURN_LAST, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_SKIP, 2'd0, 8'd0, 8'd0);
		for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
			send_beat(3'(c), 2'd3, 8'hFF, 8'hFF);
		send_beat(ipv4e_pkg::CMD_LOAD, ipv4e_pkg::LAST_OCTET, 8'hFF, 8'hFF);
		settle();

		// counting across the top of the address space
		configure(1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_REWIND, 2'd0, 8'd0, 8'd0);
		repeat (3) send_beat(ipv4e_pkg::CMD_NEXT, 2'd0, 8'd0, 8'd0);
		settle();

		// whole space, 2^32 addresses
		configure(1'b0, 32'h0, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_REWIND, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_NEXT, 2'd0, 8'd0, 8'd0);
		settle();

		// end below current address, then start above end
		configure(1'b0, 32'h7, 32'h0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_NEXT, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_REWIND, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_RETURN_LAST, 2'd0, 8'd0, 8'd0);
		settle();

		// lists of 2, 1, 3, 2 entries: 12 addresses, skips of 6, 6 and 2
		configure(1'b1, 32'h0, 32'h0, 8'd1, 8'd0, 8'd2, 8'd1);
		send_beat(ipv4e_pkg::CMD_RETURN_LAST, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_NEXT, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_SKIP, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_SKIP, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_SKIP, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_SKIP, 2'd1, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_SKIP, 2'd2, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_SKIP, ipv4e_pkg::LAST_OCTET, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_RETURN_LAST, 2'd0, 8'd0, 8'd0);
		send_beat(ipv4e_pkg::CMD_NEXT, 2'd0, 8'd0, 8'd0);
		settle();

		for (int phase = 0; beats_sent < TOTAL_BEATS; phase++) begin
			for (int k = 0; k < ipv4e_pkg::NUM_OCTETS; k++)
				l[k] = (phase == 4) ? 8'd255 : pick_last();
			case ($urandom_range(0, 9))
				0: begin
					first      = 32'hFFFF_FFFF - 32'($urandom_range(0, 12));
					final_addr = 32'hFFFF_FFFF;
				end
				1: begin
					first      = '0;
					final_addr = '1;
				end
				2: begin
					first      = $urandom;
					final_addr = $urandom;
				end
				default: begin
					first      = $urandom;
					final_addr = first + 32'($urandom_range(0, 40));
				end
			endcase
			configure((phase == 4) ? 1'b1 : 1'($urandom), first, final_addr,
				l[0], l[1], l[2], l[3]);
			n = $urandom_range(20, 80);
			for (int i = 0; i < n; i++) begin
				r   = $urandom_range(0, 99);
				sel = 2'($urandom);
				if (r < (cur_mode ? 55 : 65)) begin
					cmd = ipv4e_pkg::CMD_NEXT;
				end else if (r < 75) begin
					cmd = ipv4e_pkg::CMD_RETURN_LAST;
				end else if (r < 86) begin
					cmd = ipv4e_pkg::CMD_SKIP;
					if (cur_mode && r < 84)
						sel = 2'($urandom_range(0, 2));
				end else if (r < 91) begin
					cmd = ipv4e_pkg::CMD_REWIND;
				end else if (r < 96) begin
					cmd = ipv4e_pkg::CMD_LOAD;
				end else begin
					cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
				end
				send_beat(cmd, sel, 8'($urandom), 8'($urandom));
			end
			settle();
		end

		$display("Covered %0d command beats and %0d checked results over %0d register settings,",
			beats_sent, results_checked, phases_run);
		$display("both counting modes, list sizes 1 to 256 and blocks up to the full 2^32.");
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
